@@ rtl/cprc_pkg.sv @@
// Package for the calibrated proximity repetition counter.
// Widths, reset values, register and phase codes, shared structs. No dependencies.
package cprc_pkg;

   localparam int DIST_W     = 12;
   localparam int SLACK_W    = 8;
   localparam int CAL_W      = 5;
   localparam int SCORE_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int WINDOW_LEN_DEF  = 5;
   localparam int OUTLIER_RUN_DEF = 3;

   localparam logic [SCORE_W-1:0] SCORE_MAX   = SCORE_W'(9999);
   localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(8);
   localparam logic [DIST_W-1:0]  JUMP_RESET  = DIST_W'(100);
   localparam logic [CAL_W-1:0]   STEPS_RESET = CAL_W'(20);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLACK_BAND = 2'd0,
      CSR_JUMP_LIMIT = 2'd1,
      CSR_CAL_STEPS  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CAL_UP   = 2'd0,
      PHASE_CAL_DOWN = 2'd1,
      PHASE_COUNTING = 2'd2
   } phase_type;

   typedef struct packed {
      logic [SLACK_W-1:0] slack_band;
      logic [DIST_W-1:0]  jump_limit;
      logic [CAL_W-1:0]   calibration_steps;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [SCORE_W-1:0] rep_score;
      logic               rep_counted;
   } trk_status_type;

endpackage

@@ rtl/cprc_intf.sv @@
// Valid/ready channel interfaces: request, response and register write.
// Depends on cprc_pkg.
interface cprc_req_if;
   logic                        valid;
   logic                        ready;
   logic [cprc_pkg::DIST_W-1:0] distance_cm;

   modport source (output valid, output distance_cm, input ready);
   modport sink   (input valid, input distance_cm, output ready);
endinterface

interface cprc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cprc_pkg::DIST_W-1:0]  mean_distance;
   cprc_pkg::phase_type          phase;
   logic [cprc_pkg::SCORE_W-1:0] rep_score;
   logic                         rep_counted;

   modport source (output valid, output mean_distance, output phase, output rep_score,
                   output rep_counted, input ready);
   modport sink   (input valid, input mean_distance, input phase, input rep_score,
                   input rep_counted, output ready);
endinterface

interface cprc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cprc_pkg::CSR_IDX_W-1:0]  index;
   logic [cprc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cprc_window.sv @@
// Sample window with outlier side buffer and window mean.
// Depends on cprc_pkg.
module cprc_window #(
   parameter int WINDOW_LEN  = cprc_pkg::WINDOW_LEN_DEF,
   parameter int OUTLIER_RUN = cprc_pkg::OUTLIER_RUN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [cprc_pkg::DIST_W-1:0] distance,
   input  logic [cprc_pkg::DIST_W-1:0] jump_limit,
   output logic [cprc_pkg::DIST_W-1:0] mean
);

   localparam int DW       = cprc_pkg::DIST_W;
   localparam int POS_W    = $clog2(WINDOW_LEN);
   localparam int CNT_W    = $clog2(OUTLIER_RUN + 1);
   localparam int SUM_W    = DW + $clog2(WINDOW_LEN);
   localparam int SHIFT    = SUM_W + $clog2(WINDOW_LEN);
   localparam int RECIP_W  = SUM_W + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
   localparam int COPY_N   = (OUTLIER_RUN < WINDOW_LEN) ? OUTLIER_RUN : WINDOW_LEN;
   localparam int RUN_POS  = (OUTLIER_RUN < WINDOW_LEN) ? OUTLIER_RUN : 0;
   localparam int LAST_POS = WINDOW_LEN - 1;
   localparam int HALF_A   = (WINDOW_LEN < 8) ? WINDOW_LEN : 8;

   logic [DW-1:0]    win_ff [WINDOW_LEN];
   logic [DW-1:0]    win_in [WINDOW_LEN];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [DW-1:0]    buf_ff [OUTLIER_RUN];
   logic [DW-1:0]    buf_in [OUTLIER_RUN];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [DW-1:0]     prev;
   logic [DW-1:0]     diff;
   logic              outlier;
   logic [SUM_W-1:0]  sum_a, sum_b, sum;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0] prod;

   always_comb begin
      win_in = win_ff;
      buf_in = buf_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      prev   = '0;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         if (pos_ff == POS_W'(i)) begin
            prev = win_ff[i-1];
         end
      end
      diff    = (prev > distance) ? (prev - distance) : (distance - prev);
      // position zero never checks for a jump
      outlier = (pos_ff != '0) && (diff > jump_limit);
      if (outlier) begin
         for (int i = 0; i < OUTLIER_RUN; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               buf_in[i] = distance;
            end
         end
         if (cnt_ff == CNT_W'(OUTLIER_RUN - 1)) begin
            // run complete: buffer overwrites the head of the window
            for (int i = 0; i < COPY_N; i++) begin
               win_in[i] = buf_in[i];
            end
            pos_in = POS_W'(RUN_POS);
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else begin
         cnt_in = '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (pos_ff == POS_W'(i)) begin
               win_in[i] = distance;
            end
         end
         pos_in = (pos_ff == POS_W'(LAST_POS)) ? '0 : pos_ff + POS_W'(1);
      end
   end

   // window sum in two halves, then divide by the window length via reciprocal
   always_comb begin
      sum_a = '0;
      sum_b = '0;
      for (int i = 0; i < HALF_A; i++) begin
         sum_a = sum_a + SUM_W'(win_in[i]);
      end
      for (int i = 8; i < WINDOW_LEN; i++) begin
         sum_b = sum_b + SUM_W'(win_in[i]);
      end
      sum   = sum_a + sum_b;
      recip = RECIP_W'(RECIP);
      prod  = PROD_W'(sum) * PROD_W'(recip);
      mean  = prod[SHIFT +: DW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            win_ff[i] <= '0;
         end
         pos_ff <= '0;
         cnt_ff <= '0;
      end else if (step) begin
         win_ff <= win_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         buf_ff <= buf_in;
      end
   end

endmodule

@@ rtl/cprc_tracker.sv @@
// Level calibration and repetition counting on the window mean.
// Depends on cprc_pkg.
module cprc_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [cprc_pkg::DIST_W-1:0] mean,
   input  cprc_pkg::cfg_type           cfg,
   output cprc_pkg::trk_status_type    status
);

   localparam int DW   = cprc_pkg::DIST_W;
   localparam int SW   = cprc_pkg::SCORE_W;
   localparam int CW   = cprc_pkg::CAL_W;
   localparam int BW   = DW + 1;

   logic [DW-1:0] up_ff, up_in;
   logic [DW-1:0] down_ff, down_in;
   logic [CW-1:0] cal_ff, cal_in;
   logic          await_ff, await_in;
   logic [SW-1:0] score_ff, score_in;
   logic          counted;
   logic          in_up, in_down;
   logic [BW-1:0] mean_hi, up_hi, down_hi;

   always_comb begin
      up_in    = up_ff;
      down_in  = down_ff;
      cal_in   = cal_ff;
      await_in = await_ff;
      score_in = score_ff;
      counted  = 1'b0;

      if (up_ff == '0) begin
         if (cal_in >= cfg.calibration_steps) begin
            cal_in = '0;
            up_in  = mean;
         end else begin
            cal_in = cal_in + CW'(1);
         end
      end
      // down level may latch on the same item as the up level
      if ((up_in != '0) && (down_ff == '0)) begin
         if (cal_in >= cfg.calibration_steps) begin
            cal_in  = '0;
            down_in = mean;
         end else begin
            cal_in = cal_in + CW'(1);
         end
      end

      mean_hi = BW'(mean) + BW'(cfg.slack_band);
      up_hi   = BW'(up_in) + BW'(cfg.slack_band);
      down_hi = BW'(down_in) + BW'(cfg.slack_band);
      in_up   = (mean_hi >= BW'(up_in)) && (BW'(mean) <= up_hi);
      in_down = (mean_hi >= BW'(down_in)) && (BW'(mean) <= down_hi);

      if ((up_in != '0) && (down_in != '0)) begin
         if (await_ff) begin
            if (in_up) begin
               await_in = 1'b0;
               counted  = 1'b1;
               if (score_ff != cprc_pkg::SCORE_MAX) begin
                  score_in = score_ff + SW'(1);
               end
            end
         end else if (in_down) begin
            await_in = 1'b1;
         end
      end

      if (up_in == '0) begin
         status.phase = cprc_pkg::PHASE_CAL_UP;
      end else if (down_in == '0) begin
         status.phase = cprc_pkg::PHASE_CAL_DOWN;
      end else begin
         status.phase = cprc_pkg::PHASE_COUNTING;
      end
      status.rep_score   = score_in;
      status.rep_counted = counted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff    <= '0;
         down_ff  <= '0;
         cal_ff   <= '0;
         await_ff <= 1'b1;
         score_ff <= '0;
      end else if (step) begin
         up_ff    <= up_in;
         down_ff  <= down_in;
         cal_ff   <= cal_in;
         await_ff <= await_in;
         score_ff <= score_in;
      end
   end

endmodule

@@ rtl/calibrated_proximity_rep_counter.sv @@
// Top level of the calibrated proximity repetition counter.
// Depends on cprc_pkg, cprc_intf, cprc_window and cprc_tracker.
//
//   channel  modport  handshake         payload
//   req_ch   sink     valid / ready     distance_cm
//   rsp_ch   source   valid / ready     mean_distance, phase, rep_score, rep_counted
//   csr_ch   sink     valid / ready     index, data (ready is always high)
//
// One request per clock sustained while rsp ready stays high. A request is held
// in the input register, then window update, mean and counter logic run in one
// pass into the response register, which drives rsp valid; the request moves on
// from the input register only when the response register is free or draining.
// Synchronous active-high reset clears window, levels, score, valid flags and configuration.
// A stalled response holds the pipe; the input register still takes a
// request whenever it is empty.
module calibrated_proximity_rep_counter #(
   parameter int WINDOW_LEN  = cprc_pkg::WINDOW_LEN_DEF,
   parameter int OUTLIER_RUN = cprc_pkg::OUTLIER_RUN_DEF
) (
   input logic   clock,
   input logic   reset,
   cprc_req_if.sink   req_ch,
   cprc_rsp_if.source rsp_ch,
   cprc_csr_if.sink   csr_ch
);

   localparam int DW = cprc_pkg::DIST_W;

   // configuration registers
   cprc_pkg::cfg_type cfg_ff;

   // input stage
   logic          in_valid_ff;
   logic [DW-1:0] in_dist_ff;

   // response stage
   logic                         out_valid_ff;
   logic [DW-1:0]                out_mean_ff;
   cprc_pkg::phase_type          out_phase_ff;
   logic [cprc_pkg::SCORE_W-1:0] out_score_ff;
   logic                         out_counted_ff;

   logic                     advance;
   logic [DW-1:0]            mean;
   cprc_pkg::trk_status_type status;

   // the input stage moves on when the response register is free or draining
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slack_band        <= cprc_pkg::SLACK_RESET;
         cfg_ff.jump_limit        <= cprc_pkg::JUMP_RESET;
         cfg_ff.calibration_steps <= cprc_pkg::STEPS_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            cprc_pkg::CSR_SLACK_BAND: begin
               cfg_ff.slack_band <= csr_ch.data[cprc_pkg::SLACK_W-1:0];
            end
            cprc_pkg::CSR_JUMP_LIMIT: begin
               cfg_ff.jump_limit <= csr_ch.data[DW-1:0];
            end
            cprc_pkg::CSR_CAL_STEPS: begin
               cfg_ff.calibration_steps <= csr_ch.data[cprc_pkg::CAL_W-1:0];
            end
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_dist_ff <= req_ch.distance_cm;
      end
   end

   cprc_window #(
      .WINDOW_LEN  (WINDOW_LEN),
      .OUTLIER_RUN (OUTLIER_RUN)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .distance   (in_dist_ff),
      .jump_limit (cfg_ff.jump_limit),
      .mean       (mean)
   );

   cprc_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .mean   (mean),
      .cfg    (cfg_ff),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mean_ff    <= mean;
         out_phase_ff   <= status.phase;
         out_score_ff   <= status.rep_score;
         out_counted_ff <= status.rep_counted;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.mean_distance = out_mean_ff;
   assign rsp_ch.phase         = out_phase_ff;
   assign rsp_ch.rep_score     = out_score_ff;
   assign rsp_ch.rep_counted   = out_counted_ff;

endmodule
